>>> rtl/per_source_flood_detector_core_macros.svh
// assertion macros for the per-source flood detector
`ifndef PER_SOURCE_FLOOD_DETECTOR_CORE_MACROS_SVH
`define PER_SOURCE_FLOOD_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, off while arst_n is low
`define PSFD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("psfd assertion failed");
// next-cycle implication on clk, off while arst_n is low
`define PSFD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("psfd assertion failed");
`else
`define PSFD_ASSERT_IMP(lbl, ante, cons)
`define PSFD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/psfd_pkg.sv
// types, constants and helper functions of the per-source flood detector
package psfd_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 1024;
	localparam int COUNTER_BITS  = 16;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int LIMIT_W = 16;
	localparam int CMP_W = (COUNTER_BITS > LIMIT_W) ? COUNTER_BITS : LIMIT_W;

	// configuration register indexes
	localparam logic [2:0] REG_WINDOW     = 3'd0;
	localparam logic [2:0] REG_TOTAL_LIM  = 3'd1;
	localparam logic [2:0] REG_SYN_LIM    = 3'd2;
	localparam logic [2:0] REG_ICMP_LIM   = 3'd3;
	localparam logic [2:0] REG_UDP_LIM    = 3'd4;
	localparam logic [2:0] REG_CONN_LIM   = 3'd5;
	localparam logic [2:0] REG_BLOCK_SECS = 3'd6;

	// register reset values
	localparam logic [15:0] RST_WINDOW     = 16'd10;
	localparam logic [15:0] RST_TOTAL_LIM  = 16'd1000;
	localparam logic [15:0] RST_SYN_LIM    = 16'd500;
	localparam logic [15:0] RST_ICMP_LIM   = 16'd200;
	localparam logic [15:0] RST_UDP_LIM    = 16'd800;
	localparam logic [15:0] RST_CONN_LIM   = 16'd100;
	localparam logic [19:0] RST_BLOCK_SECS = 20'd3600;

	// ip protocol numbers
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	// verdict codes
	localparam logic [1:0] VERD_PASS    = 2'd0;
	localparam logic [1:0] VERD_DROP    = 2'd1;
	localparam logic [1:0] VERD_BLOCK   = 2'd2;
	localparam logic [1:0] VERD_NOSLOT  = 2'd3;

	// attack kinds
	localparam logic [2:0] ATK_NONE   = 3'd0;
	localparam logic [2:0] ATK_VOLUME = 3'd1;
	localparam logic [2:0] ATK_SYN    = 3'd2;
	localparam logic [2:0] ATK_ICMP   = 3'd3;
	localparam logic [2:0] ATK_UDP    = 3'd4;
	localparam logic [2:0] ATK_CONN   = 3'd5;

	typedef logic [COUNTER_BITS-1:0] cnt_t;

	// one table entry as stored in memory
	typedef struct packed {
		logic [31:0] address;
		logic [31:0] window_start;
		cnt_t        total;
		cnt_t        syn;
		cnt_t        icmp;
		cnt_t        udp;
		cnt_t        conn;
		logic        blocked;
		logic [31:0] block_time;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// saturating counter increment
	function automatic cnt_t sat_inc(input cnt_t v);
		cnt_t r;
		r = (v == {COUNTER_BITS{1'b1}}) ? v : v + cnt_t'(1);
		return r;
	endfunction

	// count strictly above limit
	function automatic logic over_limit(input cnt_t c, input logic [LIMIT_W-1:0] lim);
		logic r;
		r = CMP_W'(c) > CMP_W'(lim);
		return r;
	endfunction

	// fresh entry holding this packet alone
	function automatic entry_t start_entry(input logic [31:0] addr, input logic [31:0] now,
			input logic syn, input logic icmp, input logic udp);
		entry_t e;
		e.address      = addr;
		e.window_start = now;
		e.total        = cnt_t'(1);
		e.syn          = cnt_t'(syn);
		e.icmp         = cnt_t'(icmp);
		e.udp          = cnt_t'(udp);
		e.conn         = cnt_t'(syn);
		e.blocked      = 1'b0;
		e.block_time   = 32'd0;
		return e;
	endfunction

endpackage

>>> rtl/psfd_ifs.sv
// packet and result channel interfaces

// packet descriptor channel
interface psfd_pkt_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_address;
	logic [7:0]  protocol;
	logic        tcp_syn;
	logic        tcp_ack;
	logic [31:0] now_seconds;

	modport source (output valid, source_address, protocol, tcp_syn, tcp_ack, now_seconds,
		input ready);
	modport sink (input valid, source_address, protocol, tcp_syn, tcp_ack, now_seconds,
		output ready);
endinterface

// verdict channel
interface psfd_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic [2:0] attack_kind;
	logic       block_lifted;

	modport source (output valid, verdict, attack_kind, block_lifted, input ready);
	modport sink (input valid, verdict, attack_kind, block_lifted, output ready);
endinterface

>>> rtl/psfd_ram.sv
// generic single-write single-read ram with registered read data
module psfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/per_source_flood_detector_core.sv
// Per-source flood detector: one packet in, one verdict out, per-source state in one RAM.
// The table is swept one entry a cycle, stopping at the matching source; a miss sweeps all
// slots in use. The verdict lands in an output register and the next packet is taken while
// it waits; the following verdict stalls until that register empties.
// Reset restores the register defaults and empties the table by clearing its fill count.
`include "per_source_flood_detector_core_macros.svh"

module per_source_flood_detector_core
	import psfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	psfd_pkt_if.sink    pkt,
	psfd_res_if.source  res,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_wr_data
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;
	localparam logic [1:0] ST_DETECT = 2'd3;

	logic [1:0]  state_q;

	// configuration registers
	logic [15:0] window_q, total_lim_q, syn_lim_q, icmp_lim_q, udp_lim_q, conn_lim_q;
	logic [19:0] block_secs_q;

	// current packet
	logic [31:0] addr_q, now_q;
	logic        syn_q, icmp_q, udp_q;

	// sweep state
	logic [CNT_W-1:0] fill_q, issue_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             found_q, stale_vld_q;
	logic [IDX_W-1:0] hit_idx_q, stale_idx_q;
	entry_t           entry_q;

	// update results
	entry_t           new_q;
	logic [IDX_W-1:0] tgt_idx_q;
	logic [1:0]       verdict_q;
	logic             lifted_q, use_free_q;

	// output register
	logic       res_valid_q;
	logic [1:0] res_verdict_q;
	logic [2:0] res_kind_q;
	logic       res_lifted_q;

	// ram ports
	logic [ENTRY_W-1:0] ram_rdata, ram_wdata;
	logic               ram_rd_en, ram_we;
	entry_t             rd_ent;

	logic pkt_acc, issue_more, hit_now, ent_stale, scan_done, table_has_free;
	logic res_free, res_load;

	// update stage outputs
	entry_t     upd_ent;
	logic [IDX_W-1:0] upd_idx;
	logic [1:0] upd_verdict;
	logic       upd_lifted, upd_use_free;

	// detect stage outputs
	logic [2:0] det_kind;
	logic [1:0] det_verdict;
	entry_t     det_ent;

	assign pkt_acc   = pkt.valid && pkt.ready;
	assign pkt.ready = (state_q == ST_IDLE);

	// sweep read side
	assign issue_more = issue_q < fill_q;
	assign ram_rd_en  = (state_q == ST_SCAN) && issue_more;
	assign rd_ent     = entry_t'(ram_rdata);
	assign hit_now    = rd_vld_s1 && (rd_ent.address == addr_q);
	assign scan_done  = !rd_vld_s1 && !issue_more;
	assign table_has_free = fill_q != CNT_W'(TABLE_ENTRIES);

	// stale test on the entry just read
	always_comb begin
		if (rd_ent.blocked) begin
			ent_stale = (now_q - rd_ent.block_time) > 32'(block_secs_q);
		end else begin
			ent_stale = (now_q - rd_ent.window_start) > 32'(window_q);
		end
	end

	// read-modify of the matched or newly taken entry
	always_comb begin
		upd_ent      = entry_q;
		upd_idx      = hit_idx_q;
		upd_verdict  = VERD_PASS;
		upd_lifted   = 1'b0;
		upd_use_free = 1'b0;
		if (found_q) begin
			if (entry_q.blocked) begin
				if ((now_q - entry_q.block_time) > 32'(block_secs_q)) begin
					upd_lifted = 1'b1;
					upd_ent    = start_entry(addr_q, now_q, syn_q, icmp_q, udp_q);
				end else begin
					upd_verdict = VERD_DROP;
				end
			end else if ((now_q - entry_q.window_start) > 32'(window_q)) begin
				upd_ent.window_start = now_q;
				upd_ent.total        = cnt_t'(1);
				upd_ent.syn          = cnt_t'(syn_q);
				upd_ent.icmp         = cnt_t'(icmp_q);
				upd_ent.udp          = cnt_t'(udp_q);
			end else begin
				upd_ent.total = sat_inc(entry_q.total);
				if (syn_q) begin
					upd_ent.syn  = sat_inc(entry_q.syn);
					upd_ent.conn = sat_inc(entry_q.conn);
				end
				if (icmp_q) begin
					upd_ent.icmp = sat_inc(entry_q.icmp);
				end
				if (udp_q) begin
					upd_ent.udp = sat_inc(entry_q.udp);
				end
			end
		end else if (table_has_free) begin
			upd_ent      = start_entry(addr_q, now_q, syn_q, icmp_q, udp_q);
			upd_idx      = fill_q[IDX_W-1:0];
			upd_use_free = 1'b1;
		end else if (stale_vld_q) begin
			upd_ent = start_entry(addr_q, now_q, syn_q, icmp_q, udp_q);
			upd_idx = stale_idx_q;
		end else begin
			upd_verdict = VERD_NOSLOT;
		end
	end

	// limit check, last limit exceeded wins
	always_comb begin
		det_kind = ATK_NONE;
		if (over_limit(new_q.total, total_lim_q)) det_kind = ATK_VOLUME;
		if (over_limit(new_q.syn, syn_lim_q))     det_kind = ATK_SYN;
		if (over_limit(new_q.icmp, icmp_lim_q))   det_kind = ATK_ICMP;
		if (over_limit(new_q.udp, udp_lim_q))     det_kind = ATK_UDP;
		if (over_limit(new_q.conn, conn_lim_q))   det_kind = ATK_CONN;
		if (verdict_q != VERD_PASS) det_kind = ATK_NONE;
		det_ent     = new_q;
		det_verdict = verdict_q;
		if (det_kind != ATK_NONE) begin
			det_ent.blocked    = 1'b1;
			det_ent.block_time = now_q;
			det_verdict        = VERD_BLOCK;
		end
	end

	// write-back together with the result
	assign res_free  = !res_valid_q || res.ready;
	assign res_load  = (state_q == ST_DETECT) && res_free;
	assign ram_we    = res_load && (verdict_q == VERD_PASS);
	assign ram_wdata = ENTRY_W'(det_ent);

	psfd_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (tgt_idx_q),
		.wr_data (ram_wdata),
		.rd_en   (ram_rd_en),
		.rd_addr (issue_q[IDX_W-1:0]),
		.rd_data (ram_rdata)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q     <= RST_WINDOW;
			total_lim_q  <= RST_TOTAL_LIM;
			syn_lim_q    <= RST_SYN_LIM;
			icmp_lim_q   <= RST_ICMP_LIM;
			udp_lim_q    <= RST_UDP_LIM;
			conn_lim_q   <= RST_CONN_LIM;
			block_secs_q <= RST_BLOCK_SECS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_WINDOW:     window_q     <= cfg_wr_data[15:0];
				REG_TOTAL_LIM:  total_lim_q  <= cfg_wr_data[15:0];
				REG_SYN_LIM:    syn_lim_q    <= cfg_wr_data[15:0];
				REG_ICMP_LIM:   icmp_lim_q   <= cfg_wr_data[15:0];
				REG_UDP_LIM:    udp_lim_q    <= cfg_wr_data[15:0];
				REG_CONN_LIM:   conn_lim_q   <= cfg_wr_data[15:0];
				REG_BLOCK_SECS: block_secs_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			issue_q     <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			stale_vld_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pkt_acc) begin
						state_q     <= ST_SCAN;
						issue_q     <= '0;
						rd_vld_s1   <= 1'b0;
						found_q     <= 1'b0;
						stale_vld_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= ram_rd_en;
					if (ram_rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (hit_now) begin
						found_q   <= 1'b1;
						rd_vld_s1 <= 1'b0;
						state_q   <= ST_UPDATE;
					end else if (rd_vld_s1 && !stale_vld_q && ent_stale) begin
						stale_vld_q <= 1'b1;
					end else if (scan_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_DETECT;
				end
				ST_DETECT: begin
					if (res_load) begin
						res_valid_q <= 1'b1;
						if (ram_we && use_free_q) begin
							fill_q <= fill_q + CNT_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pkt_acc) begin
			addr_q <= pkt.source_address;
			now_q  <= pkt.now_seconds;
			syn_q  <= (pkt.protocol == PROTO_TCP) && pkt.tcp_syn && !pkt.tcp_ack;
			icmp_q <= (pkt.protocol == PROTO_ICMP);
			udp_q  <= (pkt.protocol == PROTO_UDP);
		end
		if (ram_rd_en) begin
			rd_idx_s1 <= issue_q[IDX_W-1:0];
		end
		if ((state_q == ST_SCAN) && hit_now) begin
			entry_q   <= rd_ent;
			hit_idx_q <= rd_idx_s1;
		end
		if ((state_q == ST_SCAN) && !hit_now && rd_vld_s1 && !stale_vld_q && ent_stale) begin
			stale_idx_q <= rd_idx_s1;
		end
		if (state_q == ST_UPDATE) begin
			new_q      <= upd_ent;
			tgt_idx_q  <= upd_idx;
			verdict_q  <= upd_verdict;
			lifted_q   <= upd_lifted;
			use_free_q <= upd_use_free;
		end
		if (res_load) begin
			res_verdict_q <= det_verdict;
			res_kind_q    <= det_kind;
			res_lifted_q  <= lifted_q;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.verdict      = res_verdict_q;
	assign res.attack_kind  = res_kind_q;
	assign res.block_lifted = res_lifted_q;

	// accepted transaction starts a sweep
	`PSFD_ASSERT_NXT(a_accept_scan, pkt_acc, state_q == ST_SCAN)
	// a hit entry carries the packet's source address
	`PSFD_ASSERT_IMP(a_hit_match, (state_q == ST_UPDATE) && found_q, entry_q.address == addr_q)
	// table writes only go with a result load
	`PSFD_ASSERT_IMP(a_write_with_result, ram_we, res_load && (state_q == ST_DETECT))
	// taking a free slot grows the fill count by one
	`PSFD_ASSERT_NXT(a_fill_step, ram_we && use_free_q, fill_q == $past(fill_q) + CNT_W'(1))
	// fill count never passes the table size
	`PSFD_ASSERT_IMP(a_fill_bound, ram_we && use_free_q, fill_q < CNT_W'(TABLE_ENTRIES))

endmodule
